/* rtl/abb_pkg.sv */
// Shared types and constants for the alpha blend blitter.
// Holds the word formats of both channels, the queue entry and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package abb_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [2:0] REG_DEST_X        = 3'd0;
  localparam logic [2:0] REG_DEST_Y        = 3'd1;
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd2;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd4;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd5;

  localparam logic [8:0] SCREEN_WIDTH_RST  = 9'd400;
  localparam logic [7:0] SCREEN_HEIGHT_RST = 8'd240;

  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic [7:0] bg_red;
    logic [7:0] bg_green;
    logic [7:0] bg_blue;
  } pixel_t;

  typedef struct packed {
    logic        write_enable;
    logic [18:0] byte_address;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        last_pixel;
  } result_t;

  // Classified pixel: position is only meaningful when visible is set.
  typedef struct packed {
    logic       visible;
    logic       last;
    logic [8:0] xpos;
    logic [7:0] ypos;
    pixel_t     pix;
  } job_t;

endpackage

`default_nettype wire

/* rtl/abb_front.sv */
// Front end: configuration registers, image counters, placement and clipping.
// Depends on abb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module abb_front import abb_pkg::*; #(
  parameter int unsigned FB_STRIDE     = 240,
  parameter int unsigned MAX_IMAGE_DIM = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  input  wire logic        take,
  input  wire pixel_t      pix,
  output job_t             job
);

  localparam int CW = $clog2(MAX_IMAGE_DIM);
  localparam int DW = (CW + 2 > 13) ? CW + 2 : 13;

  logic [10:0] dest_x;
  logic [10:0] dest_y;
  logic [10:0] image_width;
  logic [10:0] image_height;
  logic [8:0]  screen_width;
  logic [7:0]  screen_height;
  logic [CW-1:0] column_count, column_count_next;
  logic [CW-1:0] row_count, row_count_next;

  logic [DW-1:0] w, h, col_inc, row_inc;
  logic signed [DW-1:0] xpos, ypos;
  logic empty, visible, last_row, last_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_x        <= '0;
      dest_y        <= '0;
      image_width   <= '0;
      image_height  <= '0;
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEST_X:        dest_x        <= cfg_data;
        REG_DEST_Y:        dest_y        <= cfg_data;
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[8:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w = (DW'(image_width) > DW'(MAX_IMAGE_DIM)) ? DW'(MAX_IMAGE_DIM) : DW'(image_width);
    h = (DW'(image_height) > DW'(MAX_IMAGE_DIM)) ? DW'(MAX_IMAGE_DIM) : DW'(image_height);
    empty = (w == '0) || (h == '0);
    xpos = signed'(DW'(column_count)) + signed'({{(DW-11){dest_x[10]}}, dest_x});
    ypos = signed'(DW'(row_count)) + signed'({{(DW-11){dest_y[10]}}, dest_y});
    visible = !empty && (xpos >= 0) && (ypos >= 0) &&
              (xpos < signed'(DW'(screen_width))) &&
              (ypos < signed'(DW'(screen_height))) &&
              (ypos < signed'(DW'(FB_STRIDE)));
    col_inc = DW'(column_count) + DW'(1);
    row_inc = DW'(row_count) + DW'(1);
    last_row = row_inc >= h;
    last_col = col_inc >= w;

    if (empty) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (last_row) begin
      row_count_next    = '0;
      column_count_next = last_col ? '0 : col_inc[CW-1:0];
    end else begin
      row_count_next    = row_inc[CW-1:0];
      column_count_next = column_count;
    end

    job.visible = visible;
    job.last    = empty || (last_row && last_col);
    job.xpos    = xpos[8:0];
    job.ypos    = ypos[7:0];
    job.pix     = pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (take) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/abb_queue.sv */
// Short first-in first-out queue between front and back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module abb_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output logic [WIDTH-1:0]      head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end

endmodule

`default_nettype wire

/* rtl/abb_back.sv */
// Back end: rotated framebuffer address, per-channel alpha blend, output register.
// Depends on abb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module abb_back import abb_pkg::*; #(
  parameter int unsigned FB_STRIDE = 240
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  input  wire job_t job,
  output logic      job_take,
  output logic      res_valid,
  input  wire logic res_ready,
  output result_t   res
);

  localparam logic [31:0] ADDR_MUL = 32'(3 * FB_STRIDE);
  localparam logic [31:0] ADDR_OFS = 32'(3 * (FB_STRIDE - 1));

  logic [31:0] addr;
  result_t res_next;

  function automatic logic [7:0] blend(input logic [7:0] fg, input logic [7:0] bg,
                                       input logic [7:0] a);
    logic [16:0] sum;
    sum = (17'(a) + 17'd1) * 17'(fg) + (17'd256 - 17'(a)) * 17'(bg);
    return sum[15:8];
  endfunction

  always_comb begin
    addr = 32'(job.xpos) * ADDR_MUL + ADDR_OFS - 32'(job.ypos) * 32'd3;
    res_next = '0;
    res_next.last_pixel = job.last;
    if (job.visible) begin
      res_next.write_enable = 1'b1;
      res_next.byte_address = addr[18:0];
      res_next.out_red   = blend(job.pix.src_red,   job.pix.bg_red,   job.pix.src_alpha);
      res_next.out_green = blend(job.pix.src_green, job.pix.bg_green, job.pix.src_alpha);
      res_next.out_blue  = blend(job.pix.src_blue,  job.pix.bg_blue,  job.pix.src_alpha);
    end
  end

  assign job_take = job_valid && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (job_take) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/alpha_blend_blit_rotated_unit.sv */
// Alpha blend blitter onto a 90 degree rotated RGB framebuffer, top level.
// Depends on abb_pkg, abb_front, abb_queue, abb_back.
//
// channel  | handshake            | word
// ---------+----------------------+------------------------------------
// px       | px_valid / px_ready  | px: source RGBA and background RGB
// wr       | wr_valid / wr_ready  | wr: enable, address, blended RGB
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One word per clock unless wr stalls; px goes through queue and output register.
// Front end classifies and counts on accept; a two-entry queue feeds the back end.
// The back end blends and computes the address into an output register.
// Reset (rst, synchronous) clears counters, queue and registers to defaults.
// A stall on wr fills the queue and then drops px_ready; cfg is always ready.
`timescale 1ns / 1ps
`default_nettype none

module alpha_blend_blit_rotated_unit import abb_pkg::*; #(
  parameter int unsigned FB_STRIDE     = 240,
  parameter int unsigned MAX_IMAGE_DIM = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  input  wire logic        px_valid,
  output logic             px_ready,
  input  wire pixel_t      px,
  output logic             wr_valid,
  input  wire logic        wr_ready,
  output result_t          wr
);

  job_t front_job;
  job_t head_job;
  logic q_full, q_empty, q_pop, take;

  assign cfg_ready = 1'b1;
  assign px_ready  = !q_full;
  assign take      = px_valid && px_ready;

  abb_front #(
    .FB_STRIDE     (FB_STRIDE),
    .MAX_IMAGE_DIM (MAX_IMAGE_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .pix       (px),
    .job       (front_job)
  );

  abb_queue #(
    .WIDTH ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (head_job)
  );

  abb_back #(
    .FB_STRIDE (FB_STRIDE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!q_empty),
    .job       (head_job),
    .job_take  (q_pop),
    .res_valid (wr_valid),
    .res_ready (wr_ready),
    .res       (wr)
  );

endmodule

`default_nettype wire

/* tb/abb_blit_checker.sv */
// Checker for the alpha blend blitter: watches the pixel, write and config channels,
// predicts every write word from its own copy of registers and counters, and compares.
// Depends on abb_pkg for the word formats and register indexes.
`timescale 1ns / 1ps

module abb_blit_checker import abb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        px_valid,
  input  logic        px_ready,
  input  pixel_t      px,
  input  logic        wr_valid,
  input  logic        wr_ready,
  input  result_t     wr,
  output int          mismatches,
  output int          writes_pending
);

  localparam int STRIDE  = 240;
  localparam int MAX_DIM = 1024;

  logic signed [10:0] off_x;
  logic signed [10:0] off_y;
  logic [10:0]        img_w;
  logic [10:0]        img_h;
  logic [8:0]         scr_w;
  logic [7:0]         scr_h;
  int                 col_pos;
  int                 row_pos;
  result_t            expected_writes[$];
  result_t            want;

  task automatic flag(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val) flag($sformatf("%s got %0d want %0d", name, got, exp_val));
  endtask

  function automatic logic [7:0] mix(input logic [7:0] fg, input logic [7:0] bg,
                                     input logic [7:0] alpha);
    logic [31:0] acc;
    acc = (32'(alpha) + 32'd1) * 32'(fg) + (32'd256 - 32'(alpha)) * 32'(bg);
    return acc[15:8];
  endfunction

  // Place, clip and blend one source pixel, then advance the column-major counters.
  function automatic result_t blit_pixel(input pixel_t p);
    result_t     r;
    int          w;
    int          h;
    int          xpos;
    int          ypos;
    logic [31:0] addr;
    logic        last_row;
    logic        last_col;
    r = '0;
    w = (int'(img_w) > MAX_DIM) ? MAX_DIM : int'(img_w);
    h = (int'(img_h) > MAX_DIM) ? MAX_DIM : int'(img_h);
    if (w == 0 || h == 0) begin
      col_pos = 0;
      row_pos = 0;
      r.last_pixel = 1'b1;
      return r;
    end
    xpos = col_pos + int'(off_x);
    ypos = row_pos + int'(off_y);
    if (xpos >= 0 && ypos >= 0 && xpos < int'(scr_w) && ypos < int'(scr_h) &&
        ypos < STRIDE) begin
      addr = 3 * (xpos * STRIDE + STRIDE - 1 - ypos);
      r.write_enable = 1'b1;
      r.byte_address = addr[18:0];
      r.out_red      = mix(p.src_red, p.bg_red, p.src_alpha);
      r.out_green    = mix(p.src_green, p.bg_green, p.src_alpha);
      r.out_blue     = mix(p.src_blue, p.bg_blue, p.src_alpha);
    end
    last_row = (row_pos + 1 >= h);
    last_col = (col_pos + 1 >= w);
    r.last_pixel = last_row && last_col;
    if (last_row) begin
      row_pos = 0;
      col_pos = last_col ? 0 : col_pos + 1;
    end else begin
      row_pos = row_pos + 1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      off_x   = '0;
      off_y   = '0;
      img_w   = '0;
      img_h   = '0;
      scr_w   = SCREEN_WIDTH_RST;
      scr_h   = SCREEN_HEIGHT_RST;
      col_pos = 0;
      row_pos = 0;
      expected_writes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEST_X:        off_x = cfg_data;
          REG_DEST_Y:        off_y = cfg_data;
          REG_IMAGE_WIDTH:   img_w = cfg_data;
          REG_IMAGE_HEIGHT:  img_h = cfg_data;
          REG_SCREEN_WIDTH:  scr_w = cfg_data[8:0];
          REG_SCREEN_HEIGHT: scr_h = cfg_data[7:0];
          default: ;
        endcase
      end
      if (wr_valid && wr_ready) begin
        if (expected_writes.size() == 0) begin
          flag($sformatf("unexpected write word %h", wr));
        end else begin
          want = expected_writes.pop_front();
          check_field("write_enable", 32'(wr.write_enable), 32'(want.write_enable));
          check_field("byte_address", 32'(wr.byte_address), 32'(want.byte_address));
          check_field("out_red", 32'(wr.out_red), 32'(want.out_red));
          check_field("out_green", 32'(wr.out_green), 32'(want.out_green));
          check_field("out_blue", 32'(wr.out_blue), 32'(want.out_blue));
          check_field("last_pixel", 32'(wr.last_pixel), 32'(want.last_pixel));
        end
      end
      if (px_valid && px_ready) expected_writes.push_back(blit_pixel(px));
    end
    writes_pending <= expected_writes.size();
  end

endmodule

/* tb/tb.sv */
// Testbench top for alpha_blend_blit_rotated_unit: drives pixel and config words,
// stalls the write channel, and gives the verdict from the checker's mismatch count.
// Depends on abb_pkg, the block, and abb_blit_checker.
`timescale 1ns / 1ps

module tb import abb_pkg::*;;

  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [10:0] cfg_data  = '0;
  logic        px_valid  = 1'b0;
  logic        px_ready;
  pixel_t      px        = '0;
  logic        wr_valid;
  logic        wr_ready  = 1'b0;
  result_t     wr;

  int mismatches;
  int writes_pending;
  int send_gap_pct   = 35;
  int recv_stall_pct = 53;
  int idle_cycles    = 0;
  int sent;
  int n;
  int w;
  int h;
  int dx;
  int dy;
  int sw;
  int sh;

  alpha_blend_blit_rotated_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .px_valid  (px_valid),
    .px_ready  (px_ready),
    .px        (px),
    .wr_valid  (wr_valid),
    .wr_ready  (wr_ready),
    .wr        (wr)
  );

  abb_blit_checker u_blit_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .px_valid       (px_valid),
    .px_ready       (px_ready),
    .px             (px),
    .wr_valid       (wr_valid),
    .wr_ready       (wr_ready),
    .wr             (wr),
    .mismatches     (mismatches),
    .writes_pending (writes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    wr_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((px_valid && px_ready) || (wr_valid && wr_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("alpha_blend_blit_rotated_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold valid across back-to-back words; drop it only for a gap.
  task automatic send_pixel(input pixel_t p);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      px_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_gap_pct) @(posedge clk);
    end
    px_valid <= 1'b1;
    px       <= p;
    do @(posedge clk); while (!px_ready);
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    p = 56'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: p.src_alpha = 8'h00;
      1: p.src_alpha = 8'hFF;
      default: ;
    endcase
    return p;
  endfunction

  task automatic drain();
    px_valid <= 1'b0;
    @(posedge clk);
    while (writes_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_blit(input logic [10:0] ox, input logic [10:0] oy,
                          input logic [10:0] iw, input logic [10:0] ih,
                          input logic [8:0] scw, input logic [7:0] sch);
    drain();
    write_reg(REG_DEST_X, ox);
    write_reg(REG_DEST_Y, oy);
    write_reg(REG_IMAGE_WIDTH, iw);
    write_reg(REG_IMAGE_HEIGHT, ih);
    write_reg(REG_SCREEN_WIDTH, {2'b00, scw});
    write_reg(REG_SCREEN_HEIGHT, {3'b000, sch});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty image straight out of reset
    send_pixel(random_pixel());

    set_blit(11'd0, 11'd0, 11'd2, 11'd2, 9'd400, 8'd240);
    send_pixel(pixel_t'({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}));
    send_pixel(pixel_t'({8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00}));
    send_pixel(pixel_t'({8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF}));
    send_pixel(pixel_t'({8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF}));

    // most negative x, most positive y: clipped
    set_blit(11'h400, 11'd1023, 11'd1, 11'd1, 9'd400, 8'd240);
    send_pixel(random_pixel());

    // far corner, rows running past the rotated buffer, column past the screen
    set_blit(11'd510, 11'd239, 11'd2, 11'd3, 9'd511, 8'd255);
    repeat (6) send_pixel(random_pixel());

    // oversized dimensions saturate; then shrink mid-image
    set_blit(11'd0, 11'd0, 11'd2047, 11'd2047, 9'd400, 8'd240);
    repeat (3) send_pixel(random_pixel());
    set_blit(11'd0, 11'd0, 11'd2047, 11'd2, 9'd400, 8'd240);
    repeat (3) send_pixel(random_pixel());
    set_blit(11'd0, 11'd0, 11'd1, 11'd1, 9'd400, 8'd240);
    send_pixel(random_pixel());

    // zero-sized screen
    set_blit(11'd0, 11'd0, 11'd3, 11'd3, 9'd0, 8'd0);
    repeat (2) send_pixel(random_pixel());

    sent = 0;
    while (sent < 430) begin
      if (sent >= 290) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end else if (sent >= 145) begin
        send_gap_pct   = 53;
        recv_stall_pct = 35;
      end
      case ($urandom_range(0, 9))
        0: w = 0;
        1: w = $urandom_range(9, 2047);
        default: w = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0: h = 0;
        1: h = $urandom_range(9, 2047);
        default: h = $urandom_range(1, 8);
      endcase
      if ($urandom_range(0, 9) < 7) begin
        dx = $urandom_range(0, 420) - 12;
        dy = $urandom_range(0, 260) - 12;
      end else begin
        dx = $urandom_range(0, 2047);
        dy = $urandom_range(0, 2047);
      end
      sw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : 400;
      sh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 240;
      set_blit(dx[10:0], dy[10:0], w[10:0], h[10:0], sw[8:0], sh[7:0]);
      if (w == 0 || h == 0) n = $urandom_range(1, 4);
      else if (w * h <= 40 && $urandom_range(0, 3) != 0) n = w * h * $urandom_range(1, 2);
      else n = $urandom_range(1, 40);
      repeat (n) begin
        send_pixel(random_pixel());
        sent++;
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("alpha_blend_blit_rotated_unit regression: pass");
    end else begin
      $display("alpha_blend_blit_rotated_unit regression: fail");
    end
    $finish;
  end

endmodule
